FILE: sv/dqis_pkg.sv
// Package for the deque with insertion sort: command and status codes,
// controller states and the result record. No dependencies.
`default_nettype none

package dqis_pkg;

    typedef enum logic [2:0] {
        KIND_PUSH_LEFT  = 3'd0,
        KIND_PUSH_RIGHT = 3'd1,
        KIND_POP_LEFT   = 3'd2,
        KIND_POP_RIGHT  = 3'd3,
        KIND_SORT       = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENDS,
        S_RESP,
        S_SORT_LOAD,
        S_SORT_STEP
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [8:0]         count;
        logic               is_empty;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/dqis_cmd_if.sv
// Command channel of the deque: valid/ready handshake with kind and value.
// Depends on nothing.
`default_nettype none

interface dqis_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

FILE: sv/dqis_rsp_if.sv
// Response channel of the deque: valid/ready handshake with status, count
// and end values. Depends on nothing.
`default_nettype none

interface dqis_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [8:0]         count;
    logic               is_empty;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;

    modport source (output valid, output status, output count, output is_empty,
                    output left_value, output right_value, input ready);
    modport sink   (input valid, input status, input count, input is_empty,
                    input left_value, input right_value, output ready);
endinterface

`default_nettype wire

FILE: sv/dqis_store.sv
// Ring store of the deque: one write port, two registered read ports.
// No package dependencies.
`default_nettype none

module dqis_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [31:0]   rdata_a,
    output logic      [31:0]   rdata_b
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: sv/dqis_ctrl.sv
// Command sequencer of the deque: pointer and count upkeep, end reads and
// the in-place insertion sort over the store. Uses dqis_pkg, dqis_cmd_if.
`default_nettype none

module dqis_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    dqis_cmd_if.sink              cmd,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output dqis_pkg::result_t     res,
    output logic                  we,
    output logic [AW-1:0]         waddr,
    output logic [31:0]           wdata,
    output logic [AW-1:0]         raddr_a,
    output logic [AW-1:0]         raddr_b,
    input  wire logic [31:0]      rdata_a,
    input  wire logic [31:0]      rdata_b
);
    import dqis_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t          state_reg, state_next;
    status_t         status_reg, status_next;
    logic [AW-1:0]   lp_reg, lp_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   outer_reg, outer_next;
    logic [AW-1:0]   inner_reg, inner_next;
    logic [31:0]     key_reg, key_next;
    logic            first_reg, first_next;
    logic            accept;
    logic            full;
    logic            empty;
    logic [31:0]     key;
    logic            shift;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(idx);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign accept = cmd.valid && cmd.ready;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign key    = first_reg ? rdata_a : key_reg;
    assign shift  = (inner_reg != '0) && ($signed(rdata_b) > $signed(key));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind_t'(cmd.kind) == KIND_SORT)
                        state_next = S_SORT_LOAD;
                    else
                        state_next = S_ENDS;
                end
            end
            S_ENDS:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            S_SORT_LOAD:
            begin
                if (outer_reg >= count_reg)
                    state_next = S_ENDS;
                else
                    state_next = S_SORT_STEP;
            end
            S_SORT_STEP:
            begin
                if (!shift)
                    state_next = S_SORT_LOAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        status_next = status_reg;
        lp_next     = lp_reg;
        count_next  = count_reg;
        outer_next  = outer_reg;
        inner_next  = inner_reg;
        key_next    = key_reg;
        first_next  = first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_DONE;
                    case (kind_t'(cmd.kind))
                        KIND_PUSH_LEFT:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                lp_next    = (lp_reg == '0) ? AW'(DEPTH - 1) : lp_reg - 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_PUSH_RIGHT:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        KIND_POP_LEFT:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                lp_next    = (lp_reg == AW'(DEPTH - 1)) ? '0 : lp_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_POP_RIGHT:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        KIND_SORT:
                        begin
                            outer_next = CW'(1);
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_SORT_LOAD:
            begin
                inner_next = outer_reg[AW-1:0];
                first_next = 1'b1;
            end
            S_SORT_STEP:
            begin
                key_next   = key;
                first_next = 1'b0;
                if (shift)
                    inner_next = inner_reg - 1'b1;
                else
                    outer_next = outer_reg + 1'b1;
            end
            default:
            begin
                first_next = first_reg;
            end
        endcase
    end

    // outputs: handshake, store ports, result
    always_comb
    begin
        cmd.ready = (state_reg == S_IDLE);
        res_valid = (state_reg == S_RESP);
        we        = 1'b0;
        waddr     = lp_reg;
        wdata     = cmd.value;
        raddr_a   = lp_reg;
        raddr_b   = empty ? lp_reg : ring_addr(lp_reg, count_reg - 1'b1);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind_t'(cmd.kind) == KIND_PUSH_LEFT && !full)
                    begin
                        we    = 1'b1;
                        waddr = (lp_reg == '0) ? AW'(DEPTH - 1) : lp_reg - 1'b1;
                    end
                    else if (kind_t'(cmd.kind) == KIND_PUSH_RIGHT && !full)
                    begin
                        we    = 1'b1;
                        waddr = ring_addr(lp_reg, count_reg);
                    end
                end
            end
            S_SORT_LOAD:
            begin
                raddr_a = ring_addr(lp_reg, outer_reg);
                raddr_b = ring_addr(lp_reg, outer_reg - 1'b1);
            end
            S_SORT_STEP:
            begin
                we      = 1'b1;
                waddr   = ring_addr(lp_reg, CW'(inner_reg));
                wdata   = shift ? rdata_b : key;
                raddr_b = (inner_reg >= AW'(2)) ? ring_addr(lp_reg, CW'(inner_reg) - CW'(2))
                                                : lp_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        res.status      = status_reg;
        res.count       = 9'(count_reg);
        res.is_empty    = empty;
        res.left_value  = empty ? '0 : $signed(rdata_a);
        res.right_value = empty ? '0 : $signed(rdata_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_DONE;
            lp_reg     <= '0;
            count_reg  <= '0;
            outer_reg  <= '0;
            inner_reg  <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            lp_reg     <= lp_next;
            count_reg  <= count_next;
            outer_reg  <= outer_next;
            inner_reg  <= inner_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

FILE: sv/deque_with_insertion_sort.sv
// Bounded double-ended queue of signed 32-bit values with in-place sort.
// Commands arrive on cmd (kind, value); one response per command leaves on
// rsp (status, count, is_empty, left_value, right_value).
// Kinds: push left, push right, pop left, pop right, sort ascending
// (stable); other kinds change nothing and report done.
// A push to a full queue reports full, a pop from an empty queue reports
// empty; an empty queue shows zero at both ends.
// Push, pop and unused kinds: after the transfer the controller reads both
// ends from the store in S_ENDS and holds the response in S_RESP; the next
// command is taken only once that response has gone to the output register.
// Sort: for each value after the first, S_SORT_LOAD reads it and its left
// neighbour, then each S_SORT_STEP writes one place, moving larger values
// right until the value lands; the ends are then read as above.
// The response sits in an output register; while rsp is stalled the next
// command is still taken and worked, and only its response waits.
// Reset empties the queue at once; store contents are not cleared.
// Uses dqis_pkg, dqis_cmd_if, dqis_rsp_if, dqis_store, dqis_ctrl.
`default_nettype none

module deque_with_insertion_sort #(
    parameter int DEPTH = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dqis_cmd_if.sink  cmd,
    dqis_rsp_if.source rsp
);
    import dqis_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic            res_valid;
    logic            res_ready;
    result_t         res;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [31:0]     wdata;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    logic [31:0]     rdata_a;
    logic [31:0]     rdata_b;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    dqis_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    dqis_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.count       = out_reg.count;
    assign rsp.is_empty    = out_reg.is_empty;
    assign rsp.left_value  = out_reg.left_value;
    assign rsp.right_value = out_reg.right_value;

endmodule

`default_nettype wire

FILE: tb/sv/deque_with_insertion_sort_test.sv
// Self-checking testbench for deque_with_insertion_sort: directed and random
// commands against a behavioural deque model with per-transfer checking.
// Depends on dqis_pkg, dqis_cmd_if, dqis_rsp_if and the block itself.
`timescale 1ns / 100ps

module deque_with_insertion_sort_test;
    import dqis_pkg::*;

    localparam int DEPTH         = 256;
    localparam int STALL_LIMIT   = 150000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

    logic clk;
    logic rst_n;

    dqis_cmd_if cmd_ch ();
    dqis_rsp_if rsp_ch ();

    deque_with_insertion_sort #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // deque model
    logic signed [31:0] deque_ring [DEPTH];
    int unsigned        deque_left;
    int unsigned        deque_fill;

    result_t expected_results [$];
    int      error_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned ring_slot(input int unsigned offset);
        return (deque_left + offset) % DEPTH;
    endfunction

    function automatic void sort_deque();
        logic signed [31:0] key;
        int unsigned        hole;
        for (int unsigned k = 1; k < deque_fill; k++)
        begin
            key  = deque_ring[ring_slot(k)];
            hole = k;
            while (hole > 0 && deque_ring[ring_slot(hole - 1)] > key)
            begin
                deque_ring[ring_slot(hole)] = deque_ring[ring_slot(hole - 1)];
                hole--;
            end
            deque_ring[ring_slot(hole)] = key;
        end
    endfunction

    function automatic result_t predict_deque(input logic [2:0] kind,
                                              input logic signed [31:0] value);
        result_t r;
        r.status = ST_DONE;
        case (kind)
            KIND_PUSH_LEFT:
                if (deque_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    deque_left = (deque_left + DEPTH - 1) % DEPTH;
                    deque_ring[deque_left] = value;
                    deque_fill++;
                end
            KIND_PUSH_RIGHT:
                if (deque_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    deque_ring[ring_slot(deque_fill)] = value;
                    deque_fill++;
                end
            KIND_POP_LEFT:
                if (deque_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    deque_left = (deque_left + 1) % DEPTH;
                    deque_fill--;
                end
            KIND_POP_RIGHT:
                if (deque_fill == 0)
                    r.status = ST_EMPTY;
                else
                    deque_fill--;
            KIND_SORT:
                sort_deque();
            default:
                ;
        endcase
        r.count = 9'(deque_fill);
        if (deque_fill == 0)
        begin
            r.is_empty    = 1'b1;
            r.left_value  = '0;
            r.right_value = '0;
        end
        else
        begin
            r.is_empty    = 1'b0;
            r.left_value  = deque_ring[ring_slot(0)];
            r.right_value = deque_ring[ring_slot(deque_fill - 1)];
        end
        return r;
    endfunction

    task automatic send_command(input logic [2:0] kind, input logic signed [31:0] value);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.kind  <= 3'($urandom);
            cmd_ch.value <= $urandom;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind  <= kind;
        cmd_ch.value <= value;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        expected_results.push_back(predict_deque(kind, value));
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(8)) - 4;
            default:
                case ($urandom_range(4))
                    0:       return VALUE_MIN;
                    1:       return VALUE_MAX;
                    2:       return -1;
                    3:       return 0;
                    default: return 1;
                endcase
        endcase
    endfunction

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_responses
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("response with no command outstanding");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                    error_count++;
                end
                if (rsp_ch.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
                    error_count++;
                end
                if (rsp_ch.left_value !== want.left_value)
                begin
                    $error("left_value: expected %0d, got %0d",
                           want.left_value, rsp_ch.left_value);
                    error_count++;
                end
                if (rsp_ch.right_value !== want.right_value)
                begin
                    $error("right_value: expected %0d, got %0d",
                           want.right_value, rsp_ch.right_value);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // pops and sort on an empty queue, ignored kinds, one-value sort
    task automatic test_empty_queue();
        send_command(KIND_POP_LEFT, VALUE_MAX);
        send_command(KIND_POP_RIGHT, VALUE_MIN);
        send_command(KIND_SORT, -1);
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
            send_command(3'(k), (k[0]) ? VALUE_MIN : VALUE_MAX);
        send_command(KIND_PUSH_LEFT, VALUE_MIN);
        send_command(KIND_SORT, 0);
        send_command(KIND_UNUSED_LAST, -1);
        send_command(KIND_POP_RIGHT, 0);
        send_command(KIND_POP_LEFT, 0);
    endtask

    // extreme values at both ends, sort, pops from each side
    task automatic test_end_values();
        send_command(KIND_PUSH_LEFT, VALUE_MAX);
        send_command(KIND_PUSH_RIGHT, VALUE_MIN);
        send_command(KIND_PUSH_LEFT, 0);
        send_command(KIND_PUSH_RIGHT, -1);
        send_command(KIND_PUSH_LEFT, 1);
        send_command(KIND_SORT, VALUE_MAX);
        send_command(KIND_POP_LEFT, VALUE_MIN);
        send_command(KIND_POP_RIGHT, VALUE_MAX);
        send_command(KIND_SORT, 0);
        send_command(KIND_POP_RIGHT, 0);
        send_command(KIND_POP_LEFT, 0);
        send_command(KIND_POP_LEFT, 0);
    endtask

    // fill with a non-increasing run of equal pairs (a long sort), pushes when full
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH; i++)
            send_command(KIND_PUSH_RIGHT, 2000000 - (i / 2) * 4001);
        send_command(KIND_PUSH_LEFT, VALUE_MIN);
        send_command(KIND_PUSH_RIGHT, VALUE_MAX);
        send_command(KIND_SORT, 0);
        send_command(KIND_POP_RIGHT, 0);
        send_command(KIND_PUSH_LEFT, VALUE_MIN);
        send_command(KIND_PUSH_RIGHT, VALUE_MAX);
        send_command(KIND_POP_LEFT, 0);
    endtask

    // random walk through fill levels: grow, shrink and mixed stretches
    task automatic test_random_commands(input int n_items, input int send_pct,
                                        input int recv_pct);
        int         mode;
        int         mode_left;
        int         push_pct;
        int         sort_permille;
        int         roll;
        logic [2:0] kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        mode          = 0;
        mode_left     = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(2);
                mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            sort_permille = (deque_fill <= 16) ? 60 : (deque_fill <= 64) ? 25 : 4;
            roll = $urandom_range(999);
            if (roll < 20)
                kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
            else if (roll < 20 + sort_permille)
                kind = KIND_SORT;
            else if ($urandom_range(99) < push_pct)
                kind = $urandom_range(1) ? KIND_PUSH_LEFT : KIND_PUSH_RIGHT;
            else
                kind = $urandom_range(1) ? KIND_POP_LEFT : KIND_POP_RIGHT;
            send_command(kind, pick_value());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.kind   = KIND_PUSH_LEFT;
        cmd_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        error_count   = 0;
        deque_left    = 0;
        deque_fill    = 0;
        send_idle_pct = 18;
        recv_idle_pct = 68;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        drain_results();
        test_end_values();
        drain_results();
        test_full_queue();
        drain_results();
        test_random_commands(455, 18, 68);
        drain_results();
        test_random_commands(455, 68, 18);
        drain_results();
        test_random_commands(455, 0, 0);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
